>>> src/prlf_pkg.sv
// types and constants shared by the page replacement block
`timescale 1ns / 1ps
package prlf_pkg;

	localparam int PAGE_W   = 20;
	localparam int FRAMES_W = 11;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int COUNT_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 8'd1;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 11'd1024;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              clear_first;
	} prlf_in_t;

	typedef struct packed {
		logic               hit;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [COUNT_W-1:0] miss_total;
		logic [COUNT_W-1:0] hit_total;
	} prlf_out_t;

endpackage

>>> src/prlf_ram.sv
// simple dual-port synchronous ram, one write and one registered read
`timescale 1ns / 1ps
module prlf_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/page_replacement_lru_fifo.sv
// top level: fifo / lru page replacement over a fully associative frame set
`timescale 1ns / 1ps
// Each request carries one page reference. Resident pages sit in three
// single-port-read rams (page tag, older link, newer link) forming a doubly
// linked list from oldest to newest; slots 0 to occupancy-1 are in use. A
// request scans the tag ram one slot per cycle, pipelined against the
// registered read. A hit finishes without reordering, an lru hit may
// relink a middle slot, a miss appends after a full scan (at once into
// an empty set) and evicts when the set is full (eviction adds a read of
// the oldest slot). The tag scan is what sets the rate. One request is
// in flight at a time; its result waits in an output register so the
// next request can be taken once the result is loaded. Configuration
// writes are always accepted.
// frames_in_use is clamped to 1..MAX_FRAMES; policy_mode 0 is fifo, 1 is lru.
module page_replacement_lru_fifo
	import prlf_pkg::*;
#(
	parameter int MAX_FRAMES = 1024,
	parameter int PAGE_BITS  = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  prlf_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output prlf_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int LW = (CW > FRAMES_W) ? CW : FRAMES_W;
	localparam int TW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_PR_RD, S_PR_LINK, S_PR_TAIL,
		S_MISS, S_EVICT, S_APPEND, S_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [FRAMES_W-1:0] frames_q;
	logic                policy_q;

	// list and counters
	logic [IW-1:0]      oldest_q, newest_q, found_q, slot_q;
	logic [CW-1:0]      count_q, issue_q;
	logic [COUNT_W-1:0] miss_cnt_q, hit_cnt_q;
	logic [TW-1:0]      tag_q;

	// scan pipeline
	logic               pend_s1;
	logic [IW-1:0]      idx_s1;

	// result
	logic               hit_q, ev_valid_q;
	logic [PAGE_W-1:0]  ev_page_q;
	logic               out_valid_q;
	prlf_out_t          out_q;

	// ram ports
	logic          frame_we, newer_we, older_we;
	logic [IW-1:0] frame_waddr, newer_waddr, older_waddr;
	logic [IW-1:0] frame_raddr, newer_raddr, older_raddr;
	logic [IW-1:0] newer_wdata, older_wdata;
	logic [TW-1:0] frame_rdata;
	logic [IW-1:0] newer_rdata, older_rdata;

	logic [LW-1:0] limit;
	logic          full;
	logic          hit_now;
	logic          in_take;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// effective frame limit clamped to 1..MAX_FRAMES
	always_comb begin
		if (frames_q == '0) begin
			limit = LW'(1);
		end else if (LW'(frames_q) > LW'(MAX_FRAMES)) begin
			limit = LW'(MAX_FRAMES);
		end else begin
			limit = LW'(frames_q);
		end
	end

	assign full    = (LW'(count_q) >= limit);
	assign hit_now = pend_s1 && (frame_rdata == tag_q);

	// read address selection
	assign frame_raddr = (state_q == S_SEARCH) ? issue_q[IW-1:0] : oldest_q;
	assign newer_raddr = (state_q == S_PR_RD) ? found_q : oldest_q;
	assign older_raddr = found_q;

	// write port selection
	always_comb begin
		frame_we    = (state_q == S_APPEND);
		frame_waddr = slot_q;
		newer_we    = 1'b0;
		newer_waddr = newest_q;
		newer_wdata = found_q;
		older_we    = 1'b0;
		older_waddr = found_q;
		older_wdata = newest_q;
		case (state_q)
			S_PR_LINK: begin
				if (found_q == oldest_q) begin
					// unlinking the oldest needs no neighbour fix-up, so it is moved to the tail here
					newer_we = 1'b1;
					older_we = 1'b1;
				end else begin
					newer_we    = 1'b1;
					newer_waddr = older_rdata;
					newer_wdata = newer_rdata;
					older_we    = 1'b1;
					older_waddr = newer_rdata;
					older_wdata = older_rdata;
				end
			end
			S_PR_TAIL: begin
				newer_we = 1'b1;
				older_we = 1'b1;
			end
			S_APPEND: begin
				if (count_q != '0) begin
					newer_we    = 1'b1;
					newer_wdata = slot_q;
					older_we    = 1'b1;
					older_waddr = slot_q;
				end
			end
			default: begin
			end
		endcase
	end

	prlf_ram #(.WIDTH(TW), .DEPTH(MAX_FRAMES)) u_frame_ram (
		.clk(clk), .we(frame_we), .waddr(frame_waddr), .wdata(tag_q),
		.raddr(frame_raddr), .rdata(frame_rdata)
	);

	prlf_ram #(.WIDTH(IW), .DEPTH(MAX_FRAMES)) u_newer_ram (
		.clk(clk), .we(newer_we), .waddr(newer_waddr), .wdata(newer_wdata),
		.raddr(newer_raddr), .rdata(newer_rdata)
	);

	prlf_ram #(.WIDTH(IW), .DEPTH(MAX_FRAMES)) u_older_ram (
		.clk(clk), .we(older_we), .waddr(older_waddr), .wdata(older_wdata),
		.raddr(older_raddr), .rdata(older_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			policy_q <= POLICY_LRU;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAMES_IN_USE: frames_q <= cfg_data[FRAMES_W-1:0];
				REG_POLICY_MODE:   policy_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			miss_cnt_q  <= '0;
			hit_cnt_q   <= '0;
			issue_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the finish state handles its own output handshake
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						tag_q      <= in_data.page_number[TW-1:0];
						hit_q      <= 1'b0;
						ev_valid_q <= 1'b0;
						ev_page_q  <= '0;
						issue_q    <= '0;
						pend_s1    <= 1'b0;
						if (in_data.clear_first) begin
							// empty the set and zero counters; the request then goes in as a miss
							count_q    <= '0;
							oldest_q   <= '0;
							newest_q   <= '0;
							miss_cnt_q <= '0;
							hit_cnt_q  <= '0;
							state_q    <= S_MISS;
						end else begin
							state_q <= (count_q == '0) ? S_MISS : S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit_now) begin
						found_q <= idx_s1;
						hit_q   <= 1'b1;
						pend_s1 <= 1'b0;
						if (hit_cnt_q != '1) begin
							hit_cnt_q <= hit_cnt_q + COUNT_W'(1);
						end
						if (policy_q == POLICY_LRU && idx_s1 != newest_q) begin
							state_q <= S_PR_RD;
						end else begin
							state_q <= S_FINISH;
						end
					end else if (issue_q < count_q) begin
						pend_s1 <= 1'b1;
						idx_s1  <= issue_q[IW-1:0];
						issue_q <= issue_q + CW'(1);
					end else if (!pend_s1) begin
						state_q <= S_MISS;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				S_PR_RD: begin
					state_q <= S_PR_LINK;
				end
				S_PR_LINK: begin
					if (found_q == oldest_q) begin
						oldest_q <= newer_rdata;
						newest_q <= found_q;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_PR_TAIL;
					end
				end
				S_PR_TAIL: begin
					newest_q <= found_q;
					state_q  <= S_FINISH;
				end
				S_MISS: begin
					if (full) begin
						state_q <= S_EVICT;
					end else begin
						slot_q  <= count_q[IW-1:0];
						state_q <= S_APPEND;
					end
				end
				S_EVICT: begin
					// victim is the oldest slot, its frame is reused
					ev_valid_q <= 1'b1;
					ev_page_q  <= PAGE_W'(frame_rdata);
					slot_q     <= oldest_q;
					if (count_q > CW'(1)) begin
						oldest_q <= newer_rdata;
					end
					count_q <= count_q - CW'(1);
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					if (count_q == '0) begin
						oldest_q <= slot_q;
					end
					newest_q <= slot_q;
					count_q  <= count_q + CW'(1);
					if (miss_cnt_q != '1) begin
						miss_cnt_q <= miss_cnt_q + COUNT_W'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_q.hit           <= hit_q;
						out_q.evicted_valid <= ev_valid_q;
						out_q.evicted_page  <= ev_page_q;
						out_q.miss_total    <= miss_cnt_q;
						out_q.hit_total     <= hit_cnt_q;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
